[rtl/core/line_walk_to_circle_boundary_core_defines.svh]
// ----------------------------------------------------------------------------
// line walk to circle boundary: assertion macros
// shared property forms used by the core's checks
// ----------------------------------------------------------------------------
`ifndef LINE_WALK_TO_CIRCLE_BOUNDARY_CORE_DEFINES_SVH
`define LINE_WALK_TO_CIRCLE_BOUNDARY_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define LWCB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LWCB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/lwcb_pkg.sv]
// ----------------------------------------------------------------------------
// lwcb_pkg
// types, codes and helpers for the line walk to circle boundary core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwcb_pkg;

    localparam int CoordW   = 16;
    localparam int RadiusW  = 7;
    localparam int StopW    = 6;
    localparam int StopSqW  = 2 * StopW;
    localparam int CountW   = 7;
    localparam int OffW     = 7;
    localparam int SqW      = 2 * OffW + 1;
    localparam int AddrW    = 2;

    localparam logic [RadiusW-1:0] RadiusMax   = 7'd69;
    localparam logic [StopW-1:0]   StopReset   = 6'd54;
    localparam logic [CountW-1:0]  LastPixelN  = 7'd63;

    // register indexes of the configuration port
    localparam logic [AddrW-1:0] REG_CENTER_X = 2'd0;
    localparam logic [AddrW-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [AddrW-1:0] REG_RADIUS   = 2'd2;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_CROSS = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } state_t;

    // floor(min(r,69) * 9 / 10); the /10 is a multiply by 205 and shift by 11,
    // exact for products below 1029
    function automatic logic [StopW-1:0] stop_of(input logic [RadiusW-1:0] r);
        logic [RadiusW-1:0] rs;
        logic [18:0]        prod;
        rs   = (r > RadiusMax) ? RadiusMax : r;
        prod = {12'd0, rs} * 19'd1845;
        return prod[11 +: StopW];
    endfunction

endpackage

[rtl/core/line_walk_to_circle_boundary_core.sv]
// ----------------------------------------------------------------------------
// line_walk_to_circle_boundary_core
// walks a line from the configured center toward a target, stops at a circle
// ----------------------------------------------------------------------------
// Each request on the slave side is a target point. The core walks a
// Bresenham-style line from the configured center toward it and sends one
// result per visited pixel, ending with either a circle crossing marker
// (squared offset reached the square of floor(radius*9/10)) or an end marker
// at the last pixel; the final result has tlast set. A target is accepted
// while idle, a setup state computes the deltas and squared stop distance,
// and the shared step unit yields each result in turn (at most 64), waiting
// while tready is low. s_tready is high only between targets. The user must
// write center and radius only while idle; the core does not enforce this.
`timescale 1ns / 1ps
`include "line_walk_to_circle_boundary_core_defines.svh"

module line_walk_to_circle_boundary_core
    import lwcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // target_x[15:0], target_y[31:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // pixel_x[15:0], pixel_y[31:16]
    output logic [1:0]           m_tuser,   // kind[1:0]
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [AddrW-1:0]     cfg_addr,
    input  logic [CoordW-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [CoordW-1:0]  center_x_reg, center_y_reg;
    logic [StopW-1:0]   stop_reg;

    logic [CoordW-1:0]  tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [CoordW-1:0]  adx_reg, adx_next, ady_reg, ady_next;
    logic [CoordW-1:0]  dist_reg, dist_next;
    logic               xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [StopSqW-1:0] stop_sq_reg, stop_sq_next;
    logic [CoordW-1:0]  px_reg, px_next, py_reg, py_next;
    logic [CoordW-1:0]  last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [CoordW-1:0]  xerr_reg, xerr_next, yerr_reg, yerr_next;
    logic [OffW-1:0]    ax_reg, ax_next, ay_reg, ay_next;
    logic [CountW-1:0]  n_reg, n_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [CoordW-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    kind_t              out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;

    // shared step unit signals
    logic               slot_free;
    logic [SqW-1:0]     sq;
    logic               crossing;
    logic               end_by_len;
    logic [CoordW:0]    xsum, ysum;
    logic               xmove, ymove;
    logic [CoordW-1:0]  sx, sy;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            stop_reg     <= StopReset;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_RADIUS:   stop_reg     <= stop_of(cfg_data[RadiusW-1:0]);
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // step unit: distance test and error update for the current position
    // ------------------------------------------------------------------
    always_comb
    begin
        sq = SqW'({7'd0, ax_reg} * {7'd0, ax_reg}) + SqW'({7'd0, ay_reg} * {7'd0, ay_reg});
        crossing   = (sq >= SqW'(stop_sq_reg));
        end_by_len = ({10'd0, n_reg} == ({1'b0, dist_reg} + 17'd2));
        xsum  = {1'b0, xerr_reg} + {1'b0, adx_reg};
        ysum  = {1'b0, yerr_reg} + {1'b0, ady_reg};
        xmove = (xsum > {1'b0, dist_reg});
        ymove = (ysum > {1'b0, dist_reg});
        // the absolute difference of each axis, for setup
        sx = (tgt_x_reg >= center_x_reg) ? (tgt_x_reg - center_x_reg)
                                         : (center_x_reg - tgt_x_reg);
        sy = (tgt_y_reg >= center_y_reg) ? (tgt_y_reg - center_y_reg)
                                         : (center_y_reg - tgt_y_reg);
    end

    assign slot_free = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_x_reg    <= tgt_x_next;
        tgt_y_reg    <= tgt_y_next;
        adx_reg      <= adx_next;
        ady_reg      <= ady_next;
        dist_reg     <= dist_next;
        xneg_reg     <= xneg_next;
        yneg_reg     <= yneg_next;
        stop_sq_reg  <= stop_sq_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        last_x_reg   <= last_x_next;
        last_y_reg   <= last_y_next;
        xerr_reg     <= xerr_next;
        yerr_reg     <= yerr_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        tgt_x_next    = tgt_x_reg;
        tgt_y_next    = tgt_y_reg;
        adx_next      = adx_reg;
        ady_next      = ady_reg;
        dist_next     = dist_reg;
        xneg_next     = xneg_reg;
        yneg_next     = yneg_reg;
        stop_sq_next  = stop_sq_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        xerr_next     = xerr_reg;
        yerr_next     = yerr_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        n_next        = n_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    tgt_x_next = s_tdata[15:0];
                    tgt_y_next = s_tdata[31:16];
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                adx_next     = sx;
                ady_next     = sy;
                dist_next    = (sx > sy) ? sx : sy;
                xneg_next    = (tgt_x_reg < center_x_reg);
                yneg_next    = (tgt_y_reg < center_y_reg);
                stop_sq_next = {6'd0, stop_reg} * {6'd0, stop_reg};
                px_next      = center_x_reg;
                py_next      = center_y_reg;
                xerr_next    = '0;
                yerr_next    = '0;
                ax_next      = '0;
                ay_next      = '0;
                n_next       = '0;
                state_next   = ST_WALK;
            end

            ST_WALK:
            begin
                if (slot_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (end_by_len || (!crossing && (n_reg == LastPixelN)))
                    begin
                        // walk ran out: end marker on the last emitted pixel
                        out_x_next    = last_x_reg;
                        out_y_next    = last_y_reg;
                        out_kind_next = KIND_END;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (crossing)
                    begin
                        out_x_next    = px_reg;
                        out_y_next    = py_reg;
                        out_kind_next = KIND_CROSS;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_x_next    = px_reg;
                        out_y_next    = py_reg;
                        out_kind_next = KIND_PIXEL;
                        out_last_next = 1'b0;
                        last_x_next   = px_reg;
                        last_y_next   = py_reg;
                        n_next        = n_reg + 1'b1;
                        xerr_next     = xmove ? CoordW'(xsum - {1'b0, dist_reg}) : xsum[CoordW-1:0];
                        yerr_next     = ymove ? CoordW'(ysum - {1'b0, dist_reg}) : ysum[CoordW-1:0];
                        if (xmove)
                        begin
                            px_next = xneg_reg ? (px_reg - 1'b1) : (px_reg + 1'b1);
                            ax_next = ax_reg + 1'b1;
                        end
                        if (ymove)
                        begin
                            py_next = yneg_reg ? (py_reg - 1'b1) : (py_reg + 1'b1);
                            ay_next = ay_reg + 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `LWCB_ASSERT_IMPL(a_pixel_not_last, m_tvalid && (out_kind_reg == KIND_PIXEL), !out_last_reg, "line pixel carries tlast")
    `LWCB_ASSERT_IMPL(a_last_is_marker, m_tvalid && out_last_reg, (out_kind_reg == KIND_CROSS) || (out_kind_reg == KIND_END), "final result is not a marker")
    `LWCB_ASSERT_IMPL(a_offset_bounded, state_reg == ST_WALK, (ax_reg <= n_reg) && (ay_reg <= n_reg), "offset exceeds step count")
    `LWCB_ASSERT_IMPL(a_count_bounded, state_reg == ST_WALK, n_reg <= LastPixelN, "more than 63 pixels in one walk")

endmodule

[verif/line_walk_to_circle_boundary_core_test.sv]
// ----------------------------------------------------------------------------
// line_walk_to_circle_boundary_core_test
// streams target points into the core under random idling and stalls and
// checks every pixel and marker against a line walk computed in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_walk_to_circle_boundary_core_test;
    import lwcb_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 500;
    localparam int          RAD_SAT     = 69;
    localparam int          WALK_MAX    = 64;
    localparam logic [AddrW-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        kind_t             kind;
        logic              last;
    } pixel_rec_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;     // target_x[15:0], target_y[31:16]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;          // pixel_x[15:0], pixel_y[31:16]
    logic [1:0]        m_tuser;          // kind[1:0]
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic [AddrW-1:0]  cfg_addr = '0;
    logic [CoordW-1:0] cfg_data = '0;

    // bench copy of the core's registers
    logic [CoordW-1:0] cen_x = '0;
    logic [CoordW-1:0] cen_y = '0;
    int                rad_q = 60;

    logic [31:0]       target_q[$];
    pixel_rec_t        pixel_q[$];
    int                err_cnt = 0;
    int                cycle_cnt = 0;
    int                gap_left = 0;
    int                rdy_wait = 0;
    bit                calm = 1'b1;
    bit                hold_flip = 1'b0;
    bit                hold_seen = 1'b0;

    line_walk_to_circle_boundary_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic int draw_pause();
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // walk from the center toward the target and queue every result it yields
    function automatic void trace_line(input logic [CoordW-1:0] tx,
                                       input logic [CoordW-1:0] ty);
        int         adx, ady, span, incx, incy, px, py, ox, oy, xerr, yerr, t, n, ex, ey;
        longint     stop_sq, off_sq;
        bit         crossed, stopped;
        pixel_rec_t rec;
        adx  = (tx >= cen_x) ? int'(tx) - int'(cen_x) : int'(cen_x) - int'(tx);
        ady  = (ty >= cen_y) ? int'(ty) - int'(cen_y) : int'(cen_y) - int'(ty);
        incx = (tx > cen_x) ? 1 : ((tx < cen_x) ? -1 : 0);
        incy = (ty > cen_y) ? 1 : ((ty < cen_y) ? -1 : 0);
        span = (adx > ady) ? adx : ady;
        stop_sq = longint'(rad_q * 9 / 10) * longint'(rad_q * 9 / 10);
        px = int'(cen_x);
        py = int'(cen_y);
        ex = px;
        ey = py;
        xerr = 0;
        yerr = 0;
        n = 0;
        t = 0;
        crossed = 1'b0;
        stopped = 1'b0;
        while (!stopped && t <= span + 1)
        begin
            ox = px - int'(cen_x);
            oy = py - int'(cen_y);
            if (ox < 0) ox = -ox;
            if (oy < 0) oy = -oy;
            off_sq = longint'(ox) * ox + longint'(oy) * oy;
            if (off_sq >= stop_sq)
            begin
                rec = '{x: px[15:0], y: py[15:0], kind: KIND_CROSS, last: 1'b1};
                pixel_q.push_back(rec);
                crossed = 1'b1;
                stopped = 1'b1;
            end
            else if (n >= WALK_MAX - 1)
            begin
                stopped = 1'b1;
            end
            else
            begin
                rec = '{x: px[15:0], y: py[15:0], kind: KIND_PIXEL, last: 1'b0};
                pixel_q.push_back(rec);
                ex = px;
                ey = py;
                n++;
                xerr += adx;
                yerr += ady;
                if (xerr > span)
                begin
                    xerr -= span;
                    px += incx;
                end
                if (yerr > span)
                begin
                    yerr -= span;
                    py += incy;
                end
            end
            t++;
        end
        if (!crossed)
        begin
            rec = '{x: ex[15:0], y: ey[15:0], kind: KIND_END, last: 1'b1};
            pixel_q.push_back(rec);
        end
    endfunction

    // sender: one target per request, random gap after each
    always @(posedge clk)
    begin : target_drive
        int          gap_n;
        logic        vld_n;
        logic [31:0] dat_n;
        vld_n = s_tvalid;
        dat_n = s_tdata;
        gap_n = gap_left;
        if (s_tvalid && s_tready)
        begin
            trace_line(s_tdata[15:0], s_tdata[31:16]);
            gap_n = draw_pause();
            vld_n = 1'b0;
        end
        else if (!s_tvalid && gap_n > 0)
        begin
            gap_n--;
        end
        if (!vld_n && gap_n == 0 && target_q.size() != 0)
        begin
            dat_n = target_q.pop_front();
            vld_n = 1'b1;
        end
        s_tvalid <= vld_n;
        s_tdata  <= dat_n;
        gap_left <= gap_n;
    end

    // receiver: compare each result, random stall after each, long hold on request
    always @(posedge clk)
    begin : result_check
        pixel_rec_t want;
        logic       rdy_n;
        int         wait_n;
        rdy_n  = m_tready;
        wait_n = rdy_wait;
        if (m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                err_cnt <= err_cnt + 1;
                $display("%0t unexpected result: expected none, got x=%0d y=%0d kind=%0d last=%0d",
                         $time, m_tdata[15:0], m_tdata[31:16], m_tuser, m_tlast);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (want.x !== m_tdata[15:0] || want.y !== m_tdata[31:16] ||
                    want.kind !== m_tuser || want.last !== m_tlast)
                begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t mismatch: expected x=%0d y=%0d kind=%0d last=%0d,",
                             $time, want.x, want.y, want.kind, want.last);
                    $display("    got x=%0d y=%0d kind=%0d last=%0d",
                             m_tdata[15:0], m_tdata[31:16], m_tuser, m_tlast);
                end
            end
            wait_n = draw_pause();
            rdy_n  = (wait_n == 0);
        end
        else if (!m_tready)
        begin
            if (wait_n > 0)
                wait_n--;
            if (wait_n == 0)
                rdy_n = 1'b1;
        end
        if (hold_flip != hold_seen)
        begin
            hold_seen <= hold_flip;
            wait_n = HOLD_CYCLES;
            rdy_n  = 1'b0;
        end
        m_tready <= rdy_n;
        rdy_wait <= wait_n;
    end

    task automatic write_reg(input logic [AddrW-1:0] addr, input logic [CoordW-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        case (addr)
            REG_CENTER_X: cen_x = val;
            REG_CENTER_Y: cen_y = val;
            REG_RADIUS:   rad_q = (int'(val[6:0]) > RAD_SAT) ? RAD_SAT : int'(val[6:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (target_q.size() != 0 || s_tvalid || pixel_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic void add_target(input logic [CoordW-1:0] tx,
                                       input logic [CoordW-1:0] ty);
        target_q.push_back({ty, tx});
    endfunction

    // mostly near the circle so walks end inside as well as at the boundary
    function automatic logic [31:0] rand_target();
        logic [CoordW-1:0] tx, ty;
        if ($urandom_range(0, 9) < 7)
        begin
            tx = CoordW'(cen_x + $urandom_range(0, 150) - 75);
            ty = CoordW'(cen_y + $urandom_range(0, 150) - 75);
        end
        else
        begin
            tx = CoordW'($urandom);
            ty = CoordW'($urandom);
        end
        return {ty, tx};
    endfunction

    function automatic logic [CoordW-1:0] rand_radius();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'd69;
            4: return 16'd127;
            5: return CoordW'($urandom_range(0, 127));
            default: return CoordW'($urandom);
        endcase
    endfunction

    function automatic logic [CoordW-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return CoordW'($urandom_range(0, 40));
            1: return CoordW'(16'hFFFF - $urandom_range(0, 40));
            default: return CoordW'($urandom);
        endcase
    endfunction

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int ph;
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: center at origin, radius 60
        @(negedge clk);
        calm = 1'b1;
        add_target(16'd0, 16'd0);
        add_target(16'hFFFF, 16'hFFFF);
        add_target(16'd0, 16'hFFFF);
        add_target(16'd10, 16'd3);
        add_target(16'd3, 16'd40);
        wait_drained();

        // tiny radius: center is already a crossing
        write_reg(REG_CENTER_X, 16'h8000);
        write_reg(REG_CENTER_Y, 16'h8000);
        write_reg(REG_RADIUS, 16'd0);
        @(negedge clk);
        calm = 1'b0;
        add_target(16'd0, 16'd0);
        add_target(16'hFFFF, 16'hFFFF);
        add_target(16'h8000, 16'h8000);
        wait_drained();
        write_reg(REG_RADIUS, 16'd1);
        add_target(16'h8005, 16'h7FF0);
        add_target(16'hFFFF, 16'd0);
        wait_drained();

        // radius above range saturates, walks from the high corner toward lower coordinates
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_CENTER_X, 16'hFFFF);
        write_reg(REG_CENTER_Y, 16'hFFFF);
        add_target(16'd0, 16'd0);
        add_target(16'd0, 16'hFFFF);
        add_target(16'hFFFF, 16'd0);
        add_target(16'hFFFF, 16'hFFFF);
        add_target(16'hFFF0, 16'hFFC0);
        wait_drained();

        // smallest nonzero stop distance, write to the unused index is ignored
        write_reg(REG_RADIUS, 16'd2);
        write_reg(REG_CENTER_X, 16'd100);
        write_reg(REG_CENTER_Y, 16'd200);
        write_reg(REG_UNUSED, 16'h5A5A);
        add_target(16'd100, 16'd200);
        add_target(16'd101, 16'd200);
        add_target(16'd0, 16'd0);
        add_target(16'd300, 16'd200);
        wait_drained();

        write_reg(REG_RADIUS, 16'd100);
        write_reg(REG_CENTER_X, 16'd1000);
        write_reg(REG_CENTER_Y, 16'd1000);
        add_target(16'd1040, 16'd1030);
        add_target(16'd900, 16'd1000);
        add_target(16'd1003, 16'd1063);

        for (ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_reg(REG_CENTER_X, rand_coord());
            write_reg(REG_CENTER_Y, rand_coord());
            write_reg(REG_RADIUS, rand_radius());
            @(negedge clk);
            calm = (ph == 0 || ph == 4);
            for (i = 0; i < 15; i++)
                target_q.push_back(rand_target());
            // receiver holds off while the sender keeps offering targets
            if (ph == 2)
                hold_flip = ~hold_flip;
        end

        wait_drained();
        repeat (70) @(posedge clk);
        if (err_cnt == 0 && pixel_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
